// ===== hdl/square_wave_channel_unit_defines.svh =====
// Assertion macros shared by the square wave channel RTL.
// Depends on nothing; each module that checks itself includes this file.
`ifndef SQUARE_WAVE_CHANNEL_UNIT_DEFINES_SVH
`define SQUARE_WAVE_CHANNEL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked at every rising edge of i_clk, off while i_rst_n is low
`define SWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Condition that must never hold at a rising edge of i_clk
`define SWC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);
`else
`define SWC_ASSERT(lbl, prop, msg)
`define SWC_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hdl/swc_pkg.sv =====
// Shared types, codes and the duty table of the square wave channel.
// Used by swc_ctrl, swc_datapath and square_wave_channel_unit.
`timescale 1ns / 1ps

package swc_pkg;

    // Item kinds carried in the mode field
    localparam logic [2:0] MODE_ADVANCE      = 3'd0;
    localparam logic [2:0] MODE_TRIGGER      = 3'd1;
    localparam logic [2:0] MODE_LENGTH_TICK  = 3'd2;
    localparam logic [2:0] MODE_ENV_TICK     = 3'd3;
    localparam logic [2:0] MODE_SWEEP_TICK   = 3'd4;
    localparam logic [2:0] MODE_PERIOD_WRITE = 3'd5;
    localparam logic [2:0] MODE_LENGTH_WRITE = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_ENVELOPE     = 3'd0;
    localparam logic [2:0] REG_SWEEP        = 3'd1;
    localparam logic [2:0] REG_DUTY         = 3'd2;
    localparam logic [2:0] REG_LENGTH_EN    = 3'd3;
    localparam logic [2:0] REG_SWEEP_PRESENT = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 8;

    localparam logic [6:0]  LENGTH_FULL = 7'd64;
    localparam logic [11:0] PERIOD_SPAN = 12'd2048;
    // Division of the cycle count by the step interval, one bit per cycle
    localparam int          DIV_W       = 14;
    localparam logic [3:0]  DIV_LAST_BIT = 4'(DIV_W - 1);

    // Duty patterns, bit i is step i
    localparam logic [7:0] DUTY_ROWS [4] = '{
        8'b1000_0000,
        8'b1000_0001,
        8'b1110_0001,
        8'b0111_1110
    };

    function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] row;
        row = DUTY_ROWS[sel];
        return row[pos];
    endfunction

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic div_step;
        logic out_load;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_advance;
        logic div_last;
    } t_ctrl_status;

endpackage

// ===== hdl/swc_ctrl.sv =====
// Sequencer of the square wave channel: item intake, division steps, result hand-off.
// Depends on swc_pkg and square_wave_channel_unit_defines.svh.
`timescale 1ns / 1ps
`include "square_wave_channel_unit_defines.svh"

module swc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output swc_pkg::t_ctrl_cmd    o_cmd,
    input  swc_pkg::t_ctrl_status i_status
);

    swc_pkg::t_state r_state;
    swc_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = swc_pkg::ST_DECODE;
                end
            end
            swc_pkg::ST_DECODE: begin
                n_state = i_status.is_advance ? swc_pkg::ST_DIVIDE : swc_pkg::ST_DONE;
            end
            swc_pkg::ST_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = swc_pkg::ST_DONE;
                end
            end
            swc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = swc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swc_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            swc_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            swc_pkg::ST_DECODE: begin
                o_cmd.exec = 1'b1;
            end
            swc_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            swc_pkg::ST_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Hold the result flag until the item is taken
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SWC_ASSERT(a_accept_to_decode, i_in_valid && o_in_ready |=> r_state == swc_pkg::ST_DECODE,
        "accepted item did not start decoding")
    `SWC_ASSERT(a_div_exit, o_cmd.div_step && i_status.div_last |=> r_state == swc_pkg::ST_DONE,
        "division did not finish after its last bit")
    `SWC_ASSERT(a_one_result, o_cmd.out_load |=> r_out_valid && r_state == swc_pkg::ST_IDLE,
        "result load did not leave one pending result")

endmodule

// ===== hdl/swc_datapath.sv =====
// Channel state, configuration registers, shift-subtract divider and result register.
// Depends on swc_pkg and square_wave_channel_unit_defines.svh.
`timescale 1ns / 1ps
`include "square_wave_channel_unit_defines.svh"

module swc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swc_pkg::t_ctrl_cmd                  i_cmd,
    output swc_pkg::t_ctrl_status               o_status,
    input  logic                                i_cfg_valid,
    input  logic [swc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [swc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [swc_pkg::IN_USER_W-1:0]       i_item_user,  // mode
    input  logic [swc_pkg::IN_DATA_W-1:0]       i_item_data,  // cycles, period_value, length_value
    output logic [swc_pkg::OUT_DATA_W-1:0]      o_result      // sample, active
);

    // Configuration
    logic [7:0]  r_env_setup;
    logic [6:0]  r_sweep_setup;
    logic [1:0]  r_duty_sel;
    logic        r_length_en;
    logic        r_sweep_present;

    // Channel state
    logic [6:0]  r_length_left;
    logic [2:0]  r_env_count;
    logic [3:0]  r_volume;
    logic        r_dac_on;
    logic        r_chan_on;
    logic [10:0] r_shadow;
    logic [3:0]  r_sweep_count;
    logic        r_sweep_on;
    logic [10:0] r_period;
    logic [13:0] r_cycle_count;
    logic [2:0]  r_duty_pos;

    // Item being worked on
    logic [2:0]  r_mode;
    logic [7:0]  r_cycles;
    logic [10:0] r_period_in;
    logic [6:0]  r_length_in;

    // Divider
    logic [13:0] r_dividend;
    logic [13:0] r_rem;
    logic [13:0] r_divisor;
    logic [2:0]  r_quot;
    logic [3:0]  r_bit_cnt;

    logic [7:0]  r_result;

    // Field views of the configuration
    logic [2:0]  env_per;
    logic [2:0]  sweep_per;
    logic        sweep_neg;
    logic [2:0]  sweep_amt;
    logic [3:0]  sweep_reload;

    assign env_per      = r_env_setup[2:0];
    assign sweep_per    = r_sweep_setup[6:4];
    assign sweep_neg    = r_sweep_setup[3];
    assign sweep_amt    = r_sweep_setup[2:0];
    assign sweep_reload = (sweep_per != 3'd0) ? {1'b0, sweep_per} : 4'd8;

    // Sweep target: trigger checks the live period, sweep ticks use the shadow
    logic [10:0] sweep_base;
    logic [10:0] sweep_delta;
    logic [11:0] sweep_target;

    assign sweep_base   = (r_mode == swc_pkg::MODE_TRIGGER) ? r_period : r_shadow;
    assign sweep_delta  = sweep_base >> sweep_amt;
    assign sweep_target = sweep_neg ? ({1'b0, sweep_base} - {1'b0, sweep_delta})
                                    : ({1'b0, sweep_base} + {1'b0, sweep_delta});

    // Countdown helpers
    logic [2:0]  env_dec;
    logic [3:0]  sweep_dec;
    logic        trig_overflow;

    assign env_dec   = (r_env_count != 3'd0) ? r_env_count - 3'd1 : 3'd0;
    assign sweep_dec = (r_sweep_count != 4'd0) ? r_sweep_count - 4'd1 : 4'd0;
    assign trig_overflow = r_sweep_present && (sweep_amt != 3'd0) && !sweep_neg
                           && sweep_target[11];

    // Advance: new count and step interval for the divider
    logic [11:0] span;
    logic [13:0] interval;
    logic [13:0] count_sum;

    assign span      = swc_pkg::PERIOD_SPAN - {1'b0, r_period};
    assign interval  = {span, 2'b00};
    assign count_sum = r_cycle_count + {6'd0, r_cycles};

    // One restoring division step
    logic [13:0] trial;
    logic        trial_ge;
    logic [13:0] rem_next;
    logic [2:0]  quot_next;
    logic        div_last;

    assign trial     = {r_rem[12:0], r_dividend[13]};
    assign trial_ge  = trial >= r_divisor;
    assign rem_next  = trial_ge ? trial - r_divisor : trial;
    assign quot_next = {r_quot[1:0], trial_ge};
    assign div_last  = r_bit_cnt == 4'd0;

    assign o_status.is_advance = r_mode == swc_pkg::MODE_ADVANCE;
    assign o_status.div_last   = div_last;

    // Configuration writes, out-of-range indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_setup     <= '0;
            r_sweep_setup   <= '0;
            r_duty_sel      <= '0;
            r_length_en     <= 1'b0;
            r_sweep_present <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                swc_pkg::REG_ENVELOPE:      r_env_setup     <= i_cfg_data;
                swc_pkg::REG_SWEEP:         r_sweep_setup   <= i_cfg_data[6:0];
                swc_pkg::REG_DUTY:          r_duty_sel      <= i_cfg_data[1:0];
                swc_pkg::REG_LENGTH_EN:     r_length_en     <= i_cfg_data[0];
                swc_pkg::REG_SWEEP_PRESENT: r_sweep_present <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= swc_pkg::MODE_ADVANCE;
        end else if (i_cmd.load_item) begin
            r_mode <= i_item_user;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cycles    <= i_item_data[7:0];
            r_period_in <= i_item_data[18:8];
            r_length_in <= i_item_data[25:19];
        end
    end

    // Divider registers: load on every execute, shift one bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_dividend <= count_sum;
            r_rem      <= '0;
            r_divisor  <= interval;
            r_quot     <= '0;
            r_bit_cnt  <= swc_pkg::DIV_LAST_BIT;
        end else if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[12:0], 1'b0};
            r_rem      <= rem_next;
            r_quot     <= quot_next;
            r_bit_cnt  <= r_bit_cnt - 4'd1;
        end
    end

    // Channel state update per item kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_left <= '0;
            r_env_count   <= '0;
            r_volume      <= '0;
            r_dac_on      <= 1'b0;
            r_chan_on     <= 1'b0;
            r_shadow      <= '0;
            r_sweep_count <= '0;
            r_sweep_on    <= 1'b0;
            r_period      <= '0;
            r_cycle_count <= '0;
            r_duty_pos    <= '0;
        end else if (i_cmd.div_step) begin
            // Keep the remainder, advance by the quotient mod 8
            if (div_last) begin
                r_cycle_count <= rem_next;
                r_duty_pos    <= r_duty_pos + quot_next;
            end
        end else if (i_cmd.exec) begin
            case (r_mode)
                swc_pkg::MODE_TRIGGER: begin
                    if (r_length_left == 7'd0) begin
                        r_length_left <= swc_pkg::LENGTH_FULL;
                    end
                    r_env_count <= env_per;
                    r_volume    <= r_env_setup[7:4];
                    r_dac_on    <= |r_env_setup[7:3];
                    r_chan_on   <= (|r_env_setup[7:3]) && !trig_overflow;
                    if (r_sweep_present) begin
                        r_shadow      <= r_period;
                        r_sweep_count <= sweep_reload;
                        r_sweep_on    <= (sweep_per != 3'd0) || (sweep_amt != 3'd0);
                    end
                end
                swc_pkg::MODE_LENGTH_TICK: begin
                    if (r_length_en && r_length_left != 7'd0) begin
                        r_length_left <= r_length_left - 7'd1;
                        if (r_length_left == 7'd1) begin
                            r_chan_on <= 1'b0;
                        end
                    end
                end
                swc_pkg::MODE_ENV_TICK: begin
                    if (env_per != 3'd0) begin
                        if (env_dec == 3'd0) begin
                            r_env_count <= env_per;
                            if (r_env_setup[3]) begin
                                if (r_volume != 4'd15) begin
                                    r_volume <= r_volume + 4'd1;
                                end
                            end else if (r_volume != 4'd0) begin
                                r_volume <= r_volume - 4'd1;
                            end
                        end else begin
                            r_env_count <= env_dec;
                        end
                    end
                end
                swc_pkg::MODE_SWEEP_TICK: begin
                    if (r_sweep_present && r_sweep_on) begin
                        if (sweep_dec != 4'd0) begin
                            r_sweep_count <= sweep_dec;
                        end else begin
                            r_sweep_count <= sweep_reload;
                            if (sweep_per != 3'd0) begin
                                if (sweep_target[11]) begin
                                    r_chan_on <= 1'b0;
                                end else if (sweep_amt != 3'd0) begin
                                    r_shadow <= sweep_target[10:0];
                                    r_period <= sweep_target[10:0];
                                end
                            end
                        end
                    end
                end
                swc_pkg::MODE_PERIOD_WRITE: begin
                    r_period <= r_period_in;
                end
                swc_pkg::MODE_LENGTH_WRITE: begin
                    r_length_left <= (r_length_in > swc_pkg::LENGTH_FULL) ?
                                     swc_pkg::LENGTH_FULL : r_length_in;
                end
                default: begin
                    // Advance runs on the divider; the unused kind changes nothing
                end
            endcase
        end
    end

    // Result: signed level from the duty bit, zero when silent
    logic [4:0] vol_ext;
    logic [4:0] level;

    assign vol_ext = {1'b0, r_volume};

    always_comb begin
        if (r_chan_on && r_dac_on) begin
            level = swc_pkg::duty_bit(r_duty_sel, r_duty_pos) ? vol_ext : 5'd0 - vol_ext;
        end else begin
            level = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result <= {2'b00, r_chan_on, level};
        end
    end

    assign o_result = r_result;

    `SWC_ASSERT(a_rem_below_interval, i_cmd.div_step && div_last |=> r_cycle_count < r_divisor,
        "cycle count left at or above the step interval")
    `SWC_NEVER(a_length_range, r_length_left > swc_pkg::LENGTH_FULL,
        "length counter above full scale")
    `SWC_ASSERT(a_period_source,
        i_cmd.exec && r_mode != swc_pkg::MODE_SWEEP_TICK
        && r_mode != swc_pkg::MODE_PERIOD_WRITE |=> $stable(r_period),
        "period changed by an item that does not write it")

endmodule

// ===== hdl/square_wave_channel_unit.sv =====
// Top level of the square wave channel: stream ports, config port, controller and datapath.
// Depends on swc_pkg, swc_ctrl and swc_datapath.
//
//   Port group  Direction  Payload
//   s_axis      in         tuser: mode; tdata: cycles, period_value, length_value
//   m_axis      out        tdata: sample, active
//   cfg         in         i_cfg_index selects the register, i_cfg_data is written
//
// Every item gives one result. A non-advance item passes the controller through accept,
// execute and result load; an advance also runs the shift-subtract divider between
// execute and result load, which resolves one quotient bit per cycle over the 14-bit
// cycle count. Reset is synchronous and clears all channel state and configuration; no
// clearing pass. A waiting result sits in the output register while the next item is
// accepted; the controller holds its finished item only if that register is still full.
`timescale 1ns / 1ps

module square_wave_channel_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [swc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // cycles[7:0], period_value[18:8],
                                                             // length_value[25:19], zero fill
    input  logic [swc_pkg::IN_USER_W-1:0]     s_axis_tuser,  // mode[2:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [swc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // sample[4:0], active[5], zero fill
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [swc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    swc_pkg::t_ctrl_cmd    cmd;
    swc_pkg::t_ctrl_status status;

    // Configuration is taken in any cycle
    assign o_cfg_ready = 1'b1;

    swc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    swc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item_user (s_axis_tuser),
        .i_item_data (s_axis_tdata),
        .o_result    (m_axis_tdata)
    );

endmodule

// ===== bench/swc_level_monitor.sv =====
// Watches the stream and config channels of square_wave_channel_unit, predicts each level.
// Compares every output item with the oldest prediction. Depends on swc_pkg.
`timescale 1ns / 1ps

module swc_level_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [swc_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // cycles, period_value, length_value
    input  logic [swc_pkg::IN_USER_W-1:0]  s_axis_tuser,  // mode
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [swc_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // sample[4:0], active[5]
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [swc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [swc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_failures,
    output int                             o_pending,
    output int                             o_checked
);

    typedef struct packed {
        logic [4:0] sample;
        logic       active;
    } t_level;

    // Duty patterns, bit n is step n
    localparam logic [3:0][7:0] DUTY_PAT = {
        8'b0111_1110, 8'b1110_0001, 8'b1000_0001, 8'b1000_0000
    };

    // Configuration copy
    logic [7:0] env_setup;
    logic [6:0] sweep_setup;
    logic [1:0] duty_sel;
    logic       len_en;
    logic       sweep_here;

    // Channel state copy
    logic [6:0]  len_left;
    logic [2:0]  env_count;
    logic [3:0]  vol;
    logic        dac;
    logic        chan_on;
    logic [10:0] shadow;
    logic [3:0]  sweep_count;
    logic        sweep_en;
    logic [10:0] period;
    logic [13:0] cyc_acc;
    logic [2:0]  duty_pos;

    t_level levels_due[$];

    // Apply one event to the channel copy and return the level it leaves
    function automatic t_level next_level(input logic [2:0] mode, input logic [7:0] cyc,
                                          input logic [10:0] per, input logic [6:0] len);
        int     interval, acc, steps, sp, sh, delta, target, lvl;
        t_level res;
        case (mode)
            swc_pkg::MODE_ADVANCE: begin
                interval = 4 * (2048 - int'(period));
                acc      = int'(cyc_acc) + int'(cyc);
                steps    = acc / interval;
                cyc_acc  = 14'(acc - steps * interval);
                duty_pos = 3'(int'(duty_pos) + steps);
            end
            swc_pkg::MODE_TRIGGER: begin
                if (len_left == 0) len_left = swc_pkg::LENGTH_FULL;
                env_count = env_setup[2:0];
                vol       = env_setup[7:4];
                dac       = env_setup[7:3] != 0;
                chan_on   = dac;
                if (sweep_here) begin
                    sp          = sweep_setup[6:4];
                    sh          = sweep_setup[2:0];
                    shadow      = period;
                    sweep_count = (sp != 0) ? 4'(sp) : 4'd8;
                    sweep_en    = (sp != 0) || (sh != 0);
                    // Early overflow check on an upward sweep
                    if (sh != 0 && !sweep_setup[3]
                        && (int'(shadow) + (int'(shadow) >> sh)) > 2047)
                        chan_on = 1'b0;
                end
            end
            swc_pkg::MODE_LENGTH_TICK: begin
                if (len_en && len_left > 0) begin
                    len_left = len_left - 1;
                    if (len_left == 0) chan_on = 1'b0;
                end
            end
            swc_pkg::MODE_ENV_TICK: begin
                if (env_setup[2:0] != 0) begin
                    if (env_count > 0) env_count = env_count - 1;
                    if (env_count == 0) begin
                        env_count = env_setup[2:0];
                        if (env_setup[3]) begin
                            if (vol < 15) vol = vol + 1;
                        end else if (vol > 0) begin
                            vol = vol - 1;
                        end
                    end
                end
            end
            swc_pkg::MODE_SWEEP_TICK: begin
                if (sweep_here && sweep_en) begin
                    if (sweep_count > 0) sweep_count = sweep_count - 1;
                    if (sweep_count == 0) begin
                        sp          = sweep_setup[6:4];
                        sh          = sweep_setup[2:0];
                        sweep_count = (sp != 0) ? 4'(sp) : 4'd8;
                        if (sp != 0) begin
                            delta  = int'(shadow) >> sh;
                            target = sweep_setup[3] ? int'(shadow) - delta
                                                    : int'(shadow) + delta;
                            if (target > 2047) begin
                                chan_on = 1'b0;
                            end else if (sh != 0) begin
                                shadow = 11'(target);
                                period = 11'(target);
                            end
                        end
                    end
                end
            end
            swc_pkg::MODE_PERIOD_WRITE: period = per;
            swc_pkg::MODE_LENGTH_WRITE:
                len_left = (len > swc_pkg::LENGTH_FULL) ? swc_pkg::LENGTH_FULL : len;
            default: ;
        endcase
        lvl = 0;
        if (chan_on && dac) lvl = DUTY_PAT[duty_sel][duty_pos] ? int'(vol) : -int'(vol);
        res.sample = 5'(lvl);
        res.active = chan_on;
        return res;
    endfunction

    // Track config writes, predict on accepted inputs, compare accepted outputs
    always @(posedge i_clk) begin
        t_level want;
        if (!i_rst_n) begin
            env_setup   <= '0;
            sweep_setup <= '0;
            duty_sel    <= '0;
            len_en      <= 1'b0;
            sweep_here  <= 1'b0;
            len_left    = '0;
            env_count   = '0;
            vol         = '0;
            dac         = 1'b0;
            chan_on     = 1'b0;
            shadow      = '0;
            sweep_count = '0;
            sweep_en    = 1'b0;
            period      = '0;
            cyc_acc     = '0;
            duty_pos    = '0;
            levels_due.delete();
            o_failures  <= 0;
            o_checked   <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    swc_pkg::REG_ENVELOPE:      env_setup   <= i_cfg_data;
                    swc_pkg::REG_SWEEP:         sweep_setup <= i_cfg_data[6:0];
                    swc_pkg::REG_DUTY:          duty_sel    <= i_cfg_data[1:0];
                    swc_pkg::REG_LENGTH_EN:     len_en      <= i_cfg_data[0];
                    swc_pkg::REG_SWEEP_PRESENT: sweep_here  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // Check the older item first: a new input never answers in the same cycle
            if (m_axis_tvalid && m_axis_tready) begin
                if (levels_due.size() == 0) begin
                    $error("output item with no input outstanding: tdata %h", m_axis_tdata);
                    o_failures <= o_failures + 1;
                end else begin
                    want = levels_due.pop_front();
                    o_checked <= o_checked + 1;
                    if (m_axis_tdata[4:0] !== want.sample) begin
                        $error("sample mismatch: expected %0d, got %0d",
                               $signed(want.sample), $signed(m_axis_tdata[4:0]));
                        o_failures <= o_failures + 1;
                    end else if (m_axis_tdata[5] !== want.active) begin
                        $error("active mismatch: expected %0b, got %0b",
                               want.active, m_axis_tdata[5]);
                        o_failures <= o_failures + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                levels_due.push_back(next_level(s_axis_tuser, s_axis_tdata[7:0],
                                                s_axis_tdata[18:8], s_axis_tdata[25:19]));
        end
        o_pending <= levels_due.size();
    end

endmodule

// ===== bench/tb.sv =====
// Stimulus and verdict for square_wave_channel_unit: directed events, then random phases.
// Depends on swc_pkg, square_wave_channel_unit and swc_level_monitor.
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int         PHASES      = 12;
    localparam int         PHASE_ITEMS = 104;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [swc_pkg::IN_DATA_W-1:0]    s_axis_tdata;
    logic [swc_pkg::IN_USER_W-1:0]    s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [swc_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [swc_pkg::CFG_INDEX_W-1:0]  i_cfg_index;
    logic [swc_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    int failures, pending, checked;
    int gap_pct, stall_pct, items_sent;

    square_wave_channel_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    swc_level_monitor u_level_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_failures    (failures),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop for a hung run
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver side: stall at the rate of the current phase
    always @(negedge i_clk)
        m_axis_tready = (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);

    function automatic void set_idling(input int kind);
        gap_pct   = (kind == 1) ? 65 : (kind == 3) ? 33 : 0;
        stall_pct = (kind == 2) ? 65 : (kind == 3) ? 33 : 0;
    endfunction

    // Present one event at a falling edge, hold until accepted; leaves valid high
    task automatic send_event(input logic [2:0] mode, input logic [7:0] cyc,
                              input logic [10:0] per, input logic [6:0] len);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = {6'd0, len, per, cyc};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every outstanding level to come back
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Write all five registers while the channel is idle
    task automatic load_config(input logic [7:0] env, input logic [6:0] swp,
                               input logic [1:0] duty, input logic len_en, input logic swp_here);
        logic [7:0] vals [5];
        logic [2:0] idx  [5];
        vals = '{env, {1'b0, swp}, {6'd0, duty}, {7'd0, len_en}, {7'd0, swp_here}};
        idx  = '{swc_pkg::REG_ENVELOPE, swc_pkg::REG_SWEEP, swc_pkg::REG_DUTY,
                 swc_pkg::REG_LENGTH_EN, swc_pkg::REG_SWEEP_PRESENT};
        for (int n = 0; n < 5; n++) begin
            i_cfg_valid = 1'b1;
            i_cfg_index = idx[n];
            i_cfg_data  = vals[n];
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
    endtask

    // Random event, weighted toward short periods and restarted notes
    task automatic send_random();
        int         pick;
        logic [2:0] mode;
        logic [10:0] per;
        logic [6:0] len;
        pick = $urandom_range(0, 99);
        mode = (pick < 32) ? swc_pkg::MODE_ADVANCE :
               (pick < 41) ? swc_pkg::MODE_TRIGGER :
               (pick < 55) ? swc_pkg::MODE_LENGTH_TICK :
               (pick < 68) ? swc_pkg::MODE_ENV_TICK :
               (pick < 81) ? swc_pkg::MODE_SWEEP_TICK :
               (pick < 90) ? swc_pkg::MODE_PERIOD_WRITE :
               (pick < 98) ? swc_pkg::MODE_LENGTH_WRITE : MODE_UNUSED;
        per = ($urandom_range(0, 9) < 6) ? 11'($urandom_range(1800, 2047))
                                         : 11'($urandom_range(0, 2047));
        len = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(1, 64))
                                         : 7'($urandom_range(0, 127));
        send_event(mode, 8'($urandom_range(0, 255)), per, len);
    endtask

    initial begin
        logic [7:0] env;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = swc_pkg::MODE_ADVANCE;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = swc_pkg::REG_ENVELOPE;
        i_cfg_data    = '0;
        m_axis_tready = 1'b0;
        items_sent    = 0;
        set_idling(0);
        i_rst_n       = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Loud rising envelope, fast upward sweep, length counting
        set_idling(3);
        load_config(8'hFF, 7'h11, 2'd3, 1'b1, 1'b1);
        send_event(MODE_UNUSED, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_PERIOD_WRITE, 8'd0, 11'd2047, 7'd0);
        send_event(swc_pkg::MODE_ADVANCE, 8'd255, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_ADVANCE, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_LENGTH_WRITE, 8'd0, 11'd0, 7'd127);
        send_event(swc_pkg::MODE_LENGTH_WRITE, 8'd0, 11'd0, 7'd0);
        // Trigger at top period: upward sweep overflows at once
        send_event(swc_pkg::MODE_TRIGGER, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_PERIOD_WRITE, 8'd0, 11'd1000, 7'd0);
        send_event(swc_pkg::MODE_TRIGGER, 8'd0, 11'd0, 7'd0);
        repeat (8) send_event(swc_pkg::MODE_ENV_TICK, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_SWEEP_TICK, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_SWEEP_TICK, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_LENGTH_WRITE, 8'd0, 11'd0, 7'd1);
        send_event(swc_pkg::MODE_TRIGGER, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_LENGTH_TICK, 8'd0, 11'd0, 7'd0);
        drain();

        // DAC on with zero volume, no envelope pace, no sweep unit, length disabled
        load_config(8'h08, 7'h0F, 2'd0, 1'b0, 1'b0);
        send_event(swc_pkg::MODE_TRIGGER, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_ENV_TICK, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_SWEEP_TICK, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_LENGTH_TICK, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_PERIOD_WRITE, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_ADVANCE, 8'd255, 11'd0, 7'd0);
        drain();

        // DAC off: trigger leaves the channel silent
        load_config(8'h07, 7'h00, 2'd1, 1'b1, 1'b1);
        send_event(swc_pkg::MODE_TRIGGER, 8'd0, 11'd0, 7'd0);
        send_event(swc_pkg::MODE_ADVANCE, 8'd128, 11'd0, 7'd0);
        drain();

        // Random phases: extremes first, then random settings; cycle through idling kinds
        for (int ph = 0; ph < PHASES; ph++) begin
            set_idling(ph % 4);
            if (ph == 0) begin
                load_config(8'hFF, 7'h7F, 2'd3, 1'b1, 1'b1);
            end else if (ph == 1) begin
                load_config(8'h00, 7'h00, 2'd0, 1'b0, 1'b0);
            end else begin
                env = 8'($urandom_range(0, 255));
                if (env[7:3] == 0 && $urandom_range(0, 3) != 0) env[7] = 1'b1;
                load_config(env, 7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
            end
            // Open each phase with a well-formed note start
            send_event(swc_pkg::MODE_PERIOD_WRITE, 8'd0, 11'($urandom_range(1700, 2047)), 7'd0);
            send_event(swc_pkg::MODE_TRIGGER, 8'd0, 11'd0, 7'd0);
            repeat (PHASE_ITEMS - 2) send_random();
            drain();
        end

        repeat (40) @(negedge i_clk);
        $display("Covered %0d events over %0d phases of config and idling; %0d levels checked.",
                 items_sent, PHASES + 3, checked);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
